// ===== src/chcp_pkg.sv =====
// Shared types and constants for the file header and creator block parser.
package chcp_pkg;

   // Byte queue between the front and back parts
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Block ids and magic letters
   localparam logic [7:0] HDR_ID_BYTE = 8'h01;
   localparam logic [7:0] CR_ID_BYTE  = 8'h02;
   localparam logic [7:0] MAGIC_C     = 8'h43;
   localparam logic [7:0] MAGIC_A     = 8'h41;
   localparam logic [7:0] MAGIC_F     = 8'h46;

   // Fixed header size: magic, header size and animation count
   localparam logic [63:0] HDR_FIXED = 64'd20;

   // Byte positions within the fields, including the last byte of each
   localparam logic [2:0] U64_LAST_POS   = 3'd7;
   localparam logic [2:0] MAGIC_LAST_POS = 3'd3;
   localparam logic [2:0] DATE_LAST_POS  = 3'd5;
   localparam logic [2:0] YEAR_LO_POS    = 3'd0;
   localparam logic [2:0] YEAR_HI_POS    = 3'd1;
   localparam logic [2:0] DATE_FIRST_POS = 3'd2;

   // Result kinds
   localparam logic [2:0] KIND_HDR_OK  = 3'd0;
   localparam logic [2:0] KIND_HDR_ERR = 3'd1;
   localparam logic [2:0] KIND_CR_INFO = 3'd2;
   localparam logic [2:0] KIND_CR_ERR  = 3'd3;
   localparam logic [2:0] KIND_NAME    = 3'd4;

   typedef enum logic [3:0] {
      PH_HDR_ID,
      PH_HDR_LEN,
      PH_MAGIC,
      PH_HDR_SIZE,
      PH_ANIM,
      PH_SKIP,
      PH_CR_ID,
      PH_CR_LEN,
      PH_DATE,
      PH_NAME_LEN,
      PH_NAME,
      PH_DONE,
      PH_HALT
   } chcp_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } chcp_req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] block_length;
      logic [63:0] animation_count;
      logic [15:0] year;
      logic [7:0]  month;
      logic [7:0]  day;
      logic [7:0]  hour;
      logic [7:0]  minute;
      logic [63:0] name_length;
      logic [7:0]  name_char;
      logic        last;
   } chcp_rsp_type;

   // Byte with its decoded flags
   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
      logic       is_hdr_id;
      logic       is_cr_id;
      logic       is_c;
      logic       is_a;
      logic       is_f;
   } chcp_item_type;

   // Queue head as seen by the back part
   typedef struct packed {
      logic          valid;
      chcp_item_type item;
   } chcp_head_type;

endpackage

// ===== src/caff_header_creator_parser_core.sv =====
// Top level of the file header and creator block parser.
// Usage:
//   The request channel (req_valid, req_ready, req_payload) carries one file
//   byte per request; set file_start on the first byte of each file to restart
//   the parser. The response channel (rsp_valid, rsp_ready, rsp_payload)
//   carries at most one result per request: header ok with the animation
//   count, header error, creator info, creator error, or one creator name byte.
//   Bytes past the creator name, and all bytes after an error, give nothing
//   until the next file start.
// Timing:
//   A request enters a four-entry byte queue; the parser takes one byte per
//   cycle from it unless the response is stalled, and registers any result.
//   A result thus passes through the queue entry and then the response
//   register before it is presented. Sustained rate is one request per cycle
//   while rsp_ready stays high.
// Reset and stall:
//   Reset empties the queue, drops any pending response and puts the parser
//   back at the header id. While a response is pending and rsp_ready is low the
//   parser stops, and requests are still accepted until the queue holds four.
module caff_header_creator_parser_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  chcp_pkg::chcp_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output chcp_pkg::chcp_rsp_type rsp_payload
);
   import chcp_pkg::*;

   chcp_head_type head;
   logic          pop;

   chcp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .head        (head),
      .pop         (pop)
   );

   chcp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // The parser never takes a byte from an empty queue
   assert property (@(posedge clock) disable iff (reset) pop |-> head.valid)
      else $error("parser popped an empty queue");

   // The parser only advances when the response register can take a result
   assert property (@(posedge clock) disable iff (reset)
                    pop |-> (!rsp_valid || rsp_ready))
      else $error("parser advanced while the response was stalled");

   // A request accepted without a pop leaves the queue non-empty
   assert property (@(posedge clock) disable iff (reset)
                    (req_valid && req_ready && !pop) |=> head.valid)
      else $error("accepted request lost from the queue");

   // A name byte result always carries a nonzero remaining name length
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_payload.kind == KIND_NAME)
                    |-> (rsp_payload.name_length != '0))
      else $error("name byte reported with zero remaining length");

endmodule

// ===== src/chcp_front.sv =====
// Front part: accepts request bytes, decodes them and queues them for the parser.
module chcp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  chcp_pkg::chcp_req_type req_payload,
   output chcp_pkg::chcp_head_type head,
   input  logic                   pop
);
   import chcp_pkg::*;

   chcp_item_type             queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]         count_ff, count_in;
   chcp_item_type             item;
   logic                      push;

   // Decode the byte against the ids and the magic letters
   always_comb begin
      item.data_byte  = req_payload.data_byte;
      item.file_start = req_payload.file_start;
      item.is_hdr_id  = (req_payload.data_byte == HDR_ID_BYTE);
      item.is_cr_id   = (req_payload.data_byte == CR_ID_BYTE);
      item.is_c       = (req_payload.data_byte == MAGIC_C);
      item.is_a       = (req_payload.data_byte == MAGIC_A);
      item.is_f       = (req_payload.data_byte == MAGIC_F);
   end

   assign req_ready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (!push && pop) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the decoded byte
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = queue_ff[rd_ptr_ff];

endmodule

// ===== src/chcp_back.sv =====
// Back part: header and creator block state machine with the response register.
module chcp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  chcp_pkg::chcp_head_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output chcp_pkg::chcp_rsp_type  rsp_payload
);
   import chcp_pkg::*;

   chcp_phase_type phase_ff, phase_in;
   logic [2:0]     pos_ff, pos_in;
   logic [63:0]    block_ff, block_in;
   logic [63:0]    asm_ff, asm_in;
   logic [15:0]    year_ff, year_in;
   logic [31:0]    date_ff, date_in;
   logic [63:0]    remain_ff, remain_in;
   logic           rsp_valid_ff, rsp_valid_in;
   chcp_rsp_type   rsp_ff, rsp_in;

   chcp_phase_type phase_cur;
   logic [2:0]     pos_cur;
   logic [63:0]    block_cur, asm_cur, remain_cur, asm_new, remain_dec;
   logic [15:0]    year_cur;
   logic [31:0]    date_cur;
   logic [7:0]     data;
   logic           emit, magic_ok;
   chcp_rsp_type   out;

   assign pop  = head.valid && (!rsp_valid_ff || rsp_ready);
   assign data = head.item.data_byte;

   // Parse one byte
   always_comb begin
      // restart on a file start marker
      if (head.item.file_start) begin
         phase_cur  = PH_HDR_ID;
         pos_cur    = '0;
         block_cur  = '0;
         asm_cur    = '0;
         year_cur   = '0;
         date_cur   = '0;
         remain_cur = '0;
      end else begin
         phase_cur  = phase_ff;
         pos_cur    = pos_ff;
         block_cur  = block_ff;
         asm_cur    = asm_ff;
         year_cur   = year_ff;
         date_cur   = date_ff;
         remain_cur = remain_ff;
      end

      // merge the byte into its little-endian lane
      asm_new = asm_cur;
      for (int i = 0; i < 8; i++) begin
         if (pos_cur == 3'(i)) begin
            asm_new[i*8 +: 8] = asm_cur[i*8 +: 8] | data;
         end
      end
      remain_dec = remain_cur - 64'd1;

      case (pos_cur[1:0])
         2'd0:    magic_ok = head.item.is_c;
         2'd1:    magic_ok = head.item.is_a;
         default: magic_ok = head.item.is_f;
      endcase

      phase_in  = phase_cur;
      pos_in    = pos_cur;
      block_in  = block_cur;
      asm_in    = asm_cur;
      year_in   = year_cur;
      date_in   = date_cur;
      remain_in = remain_cur;
      emit      = 1'b0;
      out       = '0;

      case (phase_cur)
         PH_HDR_ID: begin
            if (!head.item.is_hdr_id) begin
               emit     = 1'b1;
               out.kind = KIND_HDR_ERR;
               phase_in = PH_HALT;
            end else begin
               asm_in   = '0;
               pos_in   = '0;
               phase_in = PH_HDR_LEN;
            end
         end
         PH_HDR_LEN: begin
            if (pos_cur == U64_LAST_POS) begin
               block_in = asm_new;
               asm_in   = '0;
               pos_in   = '0;
               phase_in = PH_MAGIC;
            end else begin
               asm_in = asm_new;
               pos_in = pos_cur + 3'd1;
            end
         end
         PH_MAGIC: begin
            if (!magic_ok) begin
               emit             = 1'b1;
               out.kind         = KIND_HDR_ERR;
               out.block_length = block_cur;
               phase_in         = PH_HALT;
            end else if (pos_cur == MAGIC_LAST_POS) begin
               pos_in   = '0;
               asm_in   = '0;
               phase_in = PH_HDR_SIZE;
            end else begin
               pos_in = pos_cur + 3'd1;
            end
         end
         PH_HDR_SIZE: begin
            if (pos_cur == U64_LAST_POS) begin
               asm_in = '0;
               pos_in = '0;
               if (asm_new != block_cur) begin
                  emit             = 1'b1;
                  out.kind         = KIND_HDR_ERR;
                  out.block_length = block_cur;
                  phase_in         = PH_HALT;
               end else begin
                  phase_in = PH_ANIM;
               end
            end else begin
               asm_in = asm_new;
               pos_in = pos_cur + 3'd1;
            end
         end
         PH_ANIM: begin
            if (pos_cur == U64_LAST_POS) begin
               emit                = 1'b1;
               out.kind            = KIND_HDR_OK;
               out.block_length    = block_cur;
               out.animation_count = asm_new;
               asm_in              = '0;
               pos_in              = '0;
               if (block_cur > HDR_FIXED) begin
                  remain_in = block_cur - HDR_FIXED;
                  phase_in  = PH_SKIP;
               end else begin
                  remain_in = '0;
                  phase_in  = PH_CR_ID;
               end
            end else begin
               asm_in = asm_new;
               pos_in = pos_cur + 3'd1;
            end
         end
         PH_SKIP: begin
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               phase_in = PH_CR_ID;
            end
         end
         PH_CR_ID: begin
            if (!head.item.is_cr_id) begin
               emit     = 1'b1;
               out.kind = KIND_CR_ERR;
               phase_in = PH_HALT;
            end else begin
               block_in  = '0;
               asm_in    = '0;
               pos_in    = '0;
               year_in   = '0;
               date_in   = '0;
               remain_in = '0;
               phase_in  = PH_CR_LEN;
            end
         end
         PH_CR_LEN: begin
            if (pos_cur == U64_LAST_POS) begin
               block_in = asm_new;
               asm_in   = '0;
               pos_in   = '0;
               phase_in = PH_DATE;
            end else begin
               asm_in = asm_new;
               pos_in = pos_cur + 3'd1;
            end
         end
         PH_DATE: begin
            if (pos_cur == YEAR_LO_POS) begin
               year_in = {8'h00, data};
            end else if (pos_cur == YEAR_HI_POS) begin
               year_in = year_cur | {data, 8'h00};
            end else begin
               for (int i = 0; i < 4; i++) begin
                  if (pos_cur == DATE_FIRST_POS + 3'(i)) begin
                     date_in[i*8 +: 8] = date_cur[i*8 +: 8] | data;
                  end
               end
            end
            if (pos_cur == DATE_LAST_POS) begin
               pos_in   = '0;
               asm_in   = '0;
               phase_in = PH_NAME_LEN;
            end else begin
               pos_in = pos_cur + 3'd1;
            end
         end
         PH_NAME_LEN: begin
            if (pos_cur == U64_LAST_POS) begin
               remain_in        = asm_new;
               asm_in           = '0;
               pos_in           = '0;
               emit             = 1'b1;
               out.kind         = KIND_CR_INFO;
               out.block_length = block_cur;
               out.year         = year_cur;
               out.month        = date_cur[7:0];
               out.day          = date_cur[15:8];
               out.hour         = date_cur[23:16];
               out.minute       = date_cur[31:24];
               out.name_length  = asm_new;
               if (asm_new == '0) begin
                  out.last = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_NAME;
               end
            end else begin
               asm_in = asm_new;
               pos_in = pos_cur + 3'd1;
            end
         end
         PH_NAME: begin
            emit             = 1'b1;
            out.kind         = KIND_NAME;
            out.block_length = block_cur;
            out.year         = year_cur;
            out.month        = date_cur[7:0];
            out.day          = date_cur[15:8];
            out.hour         = date_cur[23:16];
            out.minute       = date_cur[31:24];
            out.name_length  = remain_cur;
            out.name_char    = data;
            remain_in        = remain_dec;
            if (remain_dec == '0) begin
               out.last = 1'b1;
               phase_in = PH_DONE;
            end
         end
         default: begin
            // finished or halted: drop the byte
         end
      endcase

      // Load the response register or drain it
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = out;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR_ID;
         pos_ff       <= '0;
         block_ff     <= '0;
         asm_ff       <= '0;
         year_ff      <= '0;
         date_ff      <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            block_ff  <= block_in;
            asm_ff    <= asm_in;
            year_ff   <= year_in;
            date_ff   <= date_in;
            remain_ff <= remain_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
